[rtl/core/cal_pkg.sv]
// package: shared constants, types and month-length function for the calendar date counter
package cal_pkg;

  localparam int YEAR_BITS    = 16;
  localparam int MAX_ADD_DAYS = 1023;
  localparam int MONTHS       = 12;
  localparam int MAX_MONTH_LEN = 31;
  localparam int RESET_YEAR   = 2000;
  localparam int AccW         = $clog2(MAX_MONTH_LEN + MAX_ADD_DAYS + 1);

  localparam logic [2:0] OP_SET       = 3'd0;
  localparam logic [2:0] OP_ADD_DAY   = 3'd1;
  localparam logic [2:0] OP_ADD_MONTH = 3'd2;
  localparam logic [2:0] OP_ADD_YEAR  = 3'd3;
  localparam logic [2:0] OP_ADD_DAYS  = 3'd4;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [3:0]  new_month;
    logic [4:0]  new_day;
    logic [15:0] new_year;
    logic [9:0]  add_count;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [15:0] year_out;
  } out_item_t;

  typedef struct packed {
    logic                 over;
    logic [AccW-1:0]      diff;
    logic [3:0]           month_nxt;
    logic [YEAR_BITS-1:0] year_nxt;
    logic [YEAR_BITS-1:0] year_plus1;
  } step_res_t;

  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd2:                      len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

[rtl/core/cal_step_unit.sv]
// shared step unit: month-length compare and subtract, month and year advance
module cal_step_unit import cal_pkg::*; (
  input  logic [3:0]           month_i,
  input  logic [AccW-1:0]      acc_i,
  input  logic [YEAR_BITS-1:0] year_i,
  output step_res_t            res_o
);

  logic [AccW-1:0] len_w;

  assign len_w = AccW'(month_len(month_i));

  always_comb begin
    res_o.over       = acc_i > len_w;
    res_o.diff       = acc_i - len_w;
    res_o.year_plus1 = year_i + YEAR_BITS'(1);
    if (month_i >= 4'(MONTHS)) begin
      res_o.month_nxt = 4'd1;
      res_o.year_nxt  = year_i + YEAR_BITS'(1);
    end else begin
      res_o.month_nxt = month_i + 4'd1;
      res_o.year_nxt  = year_i;
    end
  end

endmodule

[rtl/core/calendar_date_counter_core.sv]
// top level: calendar date counter with sequencer around the shared step unit
//
// Holds a month/day/year date (no leap years, year wraps at 2^16) and applies one
// operation per transaction. Set, add day, add month, add year, unused codes and
// adding zero days all finish at the accepting edge: out_valid pulses in the next
// cycle and a new transaction may be accepted in that same cycle. Adding N days
// runs one month-length compare and subtract per cycle through the shared step
// unit until the remaining days fit within the current month length, busy high
// throughout, then out_valid pulses in the following cycle. The receiver cannot
// stall: out_valid is high for exactly one cycle, and out_data shows the current
// date, which holds until the next transaction updates it.
module calendar_date_counter_core import cal_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_valid,
  output out_item_t out_data
);

  state_t               state_r, state_nxt;
  logic [3:0]           cur_month_r, cur_month_nxt;
  logic [4:0]           cur_day_r, cur_day_nxt;
  logic [YEAR_BITS-1:0] cur_year_r, cur_year_nxt;
  logic [AccW-1:0]      acc_r, acc_nxt;
  logic                 done_r, done_nxt;
  logic [AccW-1:0]      cnt_sat;
  logic [AccW-1:0]      unit_acc;
  step_res_t            step;

  assign cnt_sat = (AccW'(in_data.add_count) > AccW'(MAX_ADD_DAYS)) ?
                   AccW'(MAX_ADD_DAYS) : AccW'(in_data.add_count);
  assign unit_acc = (state_r == ST_RUN) ? acc_r : AccW'(cur_day_r) + AccW'(1);

  cal_step_unit u_step (
    .month_i (cur_month_r),
    .acc_i   (unit_acc),
    .year_i  (cur_year_r),
    .res_o   (step)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      done_r      <= 1'b0;
      cur_month_r <= 4'd1;
      cur_day_r   <= 5'd1;
      cur_year_r  <= YEAR_BITS'(RESET_YEAR);
    end else begin
      state_r     <= state_nxt;
      done_r      <= done_nxt;
      cur_month_r <= cur_month_nxt;
      cur_day_r   <= cur_day_nxt;
      cur_year_r  <= cur_year_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    done_nxt      = 1'b0;
    cur_month_nxt = cur_month_r;
    cur_day_nxt   = cur_day_r;
    cur_year_nxt  = cur_year_r;
    acc_nxt       = acc_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          done_nxt = 1'b1;
          case (in_data.operation)
            OP_SET: begin
              if (in_data.new_month == 4'd0) begin
                cur_month_nxt = 4'd1;
              end else if (in_data.new_month > 4'(MONTHS)) begin
                cur_month_nxt = 4'(MONTHS);
              end else begin
                cur_month_nxt = in_data.new_month;
              end
              cur_day_nxt  = (in_data.new_day == 5'd0) ? 5'd1 : in_data.new_day;
              cur_year_nxt = YEAR_BITS'(in_data.new_year);
            end
            OP_ADD_DAY: begin
              if (step.over) begin
                cur_day_nxt   = 5'd1;
                cur_month_nxt = step.month_nxt;
                cur_year_nxt  = step.year_nxt;
              end else begin
                cur_day_nxt = unit_acc[4:0];
              end
            end
            OP_ADD_MONTH: begin
              cur_month_nxt = step.month_nxt;
              cur_year_nxt  = step.year_nxt;
            end
            OP_ADD_YEAR: begin
              cur_year_nxt = step.year_plus1;
            end
            OP_ADD_DAYS: begin
              if (cnt_sat != '0) begin
                acc_nxt   = AccW'(cur_day_r) + cnt_sat;
                state_nxt = ST_RUN;
                done_nxt  = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_RUN: begin
        if (step.over) begin
          acc_nxt       = step.diff;
          cur_month_nxt = step.month_nxt;
          cur_year_nxt  = step.year_nxt;
        end else begin
          cur_day_nxt = acc_r[4:0];
          done_nxt    = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy               = (state_r == ST_RUN);
  assign out_valid          = done_r;
  assign out_data.month_out = cur_month_r;
  assign out_data.day_out   = cur_day_r;
  assign out_data.year_out  = 16'(cur_year_r);

`ifndef SYNTH
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == ST_IDLE)
    else $error("result strobe while still iterating");

  a_short_op_done: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.operation != OP_ADD_DAYS) |=> out_valid)
    else $error("single-step transaction gave no result");

  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_month_r >= 4'd1) && (cur_month_r <= 4'(MONTHS)))
    else $error("month out of range");

  a_run_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && !step.over) |=> (out_valid && cur_day_r != 5'd0))
    else $error("iteration ended without a valid day");
`endif

endmodule

[verif/tb_calendar_date_counter_core.sv]
// testbench: directed and random date operations, checked against a local date model
module tb_calendar_date_counter_core import cal_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] OP_RSVD_5 = 3'd5;
  localparam logic [2:0] OP_RSVD_6 = 3'd6;
  localparam logic [2:0] OP_RSVD_7 = 3'd7;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 40;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic [3:0]  month;
    logic [4:0]  day;
    logic [15:0] year;
  } date_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_data = '0;
  logic      out_valid;
  out_item_t out_data;

  date_t cal_date;
  date_t expected_dates[$];
  int    gap_pct;
  int    sent_count;
  int    checked_count;
  int    mismatch_count;
  int    quiet_cycles;
  int    op_count[8];

  calendar_date_counter_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always #10 clk = ~clk;

  function automatic int days_in_month(input logic [3:0] m);
    if (m == 4'd2) return 28;
    if (m == 4'd4 || m == 4'd6 || m == 4'd9 || m == 4'd11) return 30;
    return 31;
  endfunction

  function automatic date_t next_month_of(input date_t d);
    date_t r;
    r = d;
    if (d.month >= 4'(MONTHS)) begin
      r.month = 4'd1;
      r.year  = d.year + 16'd1;
    end else begin
      r.month = d.month + 4'd1;
    end
    return r;
  endfunction

  function automatic date_t apply_date_op(input date_t d, input in_item_t it);
    date_t       r;
    int unsigned acc;
    int unsigned cnt;
    logic [3:0]  m;
    r = d;
    case (it.operation)
      OP_SET: begin
        m = it.new_month;
        if (m == 4'd0) m = 4'd1;
        else if (m > 4'(MONTHS)) m = 4'(MONTHS);
        r.month = m;
        r.day   = (it.new_day == 5'd0) ? 5'd1 : it.new_day;
        r.year  = it.new_year;
      end
      OP_ADD_DAY: begin
        if (int'(d.day) + 1 > days_in_month(d.month)) begin
          r = next_month_of(d);
          r.day = 5'd1;
        end else begin
          r.day = d.day + 5'd1;
        end
      end
      OP_ADD_MONTH: r = next_month_of(d);
      OP_ADD_YEAR: r.year = d.year + 16'd1;
      OP_ADD_DAYS: begin
        cnt = it.add_count;
        if (cnt > MAX_ADD_DAYS) cnt = MAX_ADD_DAYS;
        if (cnt != 0) begin
          acc = d.day + cnt;
          while (acc > days_in_month(r.month)) begin
            acc -= days_in_month(r.month);
            r = next_month_of(r);
          end
          r.day = acc[4:0];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // one transaction, then an optional sender gap
  task automatic send_date_op(input logic [2:0] op, input logic [3:0] m, input logic [4:0] d,
                              input logic [15:0] y, input logic [9:0] cnt);
    in_item_t item;
    item = '{operation: op, new_month: m, new_day: d, new_year: y, add_count: cnt};
    start   <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy);
    cal_date = apply_date_op(cal_date, item);
    expected_dates.push_back(cal_date);
    op_count[op]++;
    sent_count++;
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
  endtask

  task automatic test_reset_value();
    send_date_op(OP_ADD_DAYS, 4'd0, 5'd0, 16'd0, 10'd0);
    send_date_op(OP_RSVD_5, 4'd15, 5'd31, 16'hFFFF, 10'h3FF);
    send_date_op(OP_RSVD_6, 4'd3, 5'd9, 16'h1234, 10'd7);
    send_date_op(OP_RSVD_7, 4'd0, 5'd0, 16'd0, 10'd0);
  endtask

  task automatic test_set_clamping();
    send_date_op(OP_SET, 4'd0, 5'd0, 16'd0, 10'd0);
    send_date_op(OP_SET, 4'd15, 5'd31, 16'd1999, 10'h3FF);
    send_date_op(OP_SET, 4'd13, 5'd16, 16'hAAAA, 10'd0);
    send_date_op(OP_SET, 4'd2, 5'd31, 16'hFFFF, 10'd0);
  endtask

  task automatic test_month_end();
    send_date_op(OP_ADD_DAYS, 4'd0, 5'd0, 16'd0, 10'd0);
    send_date_op(OP_ADD_DAY, 4'd0, 5'd0, 16'd0, 10'd0);
    send_date_op(OP_SET, 4'd1, 5'd31, 16'd2001, 10'd0);
    send_date_op(OP_ADD_MONTH, 4'd0, 5'd0, 16'd0, 10'd0);
    send_date_op(OP_ADD_DAYS, 4'd0, 5'd0, 16'd0, 10'd1);
    send_date_op(OP_SET, 4'd4, 5'd31, 16'd2001, 10'd0);
    send_date_op(OP_ADD_DAY, 4'd0, 5'd0, 16'd0, 10'd0);
  endtask

  task automatic test_year_wrap();
    send_date_op(OP_SET, 4'd12, 5'd31, 16'hFFFF, 10'd0);
    send_date_op(OP_ADD_DAY, 4'd0, 5'd0, 16'd0, 10'd0);
    send_date_op(OP_SET, 4'd12, 5'd5, 16'hFFFF, 10'd0);
    send_date_op(OP_ADD_MONTH, 4'd0, 5'd0, 16'd0, 10'd0);
    send_date_op(OP_SET, 4'd6, 5'd30, 16'hFFFF, 10'd0);
    send_date_op(OP_ADD_YEAR, 4'd0, 5'd0, 16'd0, 10'd0);
  endtask

  task automatic test_add_days();
    send_date_op(OP_SET, 4'd12, 5'd31, 16'hFFFE, 10'd0);
    send_date_op(OP_ADD_DAYS, 4'd0, 5'd0, 16'd0, 10'h3FF);
  endtask

  // mostly legal operations around month and year boundaries, some noise and odd values
  task automatic test_random_traffic(input int n, input int pct);
    int unsigned pick;
    logic [2:0]  op;
    logic [3:0]  m;
    logic [4:0]  d;
    logic [15:0] y;
    logic [9:0]  cnt;
    gap_pct = pct;
    repeat (n) begin
      m    = 4'($urandom);
      d    = 5'($urandom);
      y    = 16'($urandom);
      cnt  = 10'($urandom);
      pick = $urandom_range(99);
      if (pick < 20) op = OP_SET;
      else if (pick < 45) op = OP_ADD_DAY;
      else if (pick < 57) op = OP_ADD_MONTH;
      else if (pick < 65) op = OP_ADD_YEAR;
      else if (pick < 95) op = OP_ADD_DAYS;
      else op = 3'($urandom_range(OP_RSVD_5, OP_RSVD_7));
      if (op == OP_SET) begin
        if ($urandom_range(9) < 8) m = 4'($urandom_range(1, MONTHS));
        if ($urandom_range(9) < 5) d = 5'($urandom_range(27, 31));
        if ($urandom_range(9) < 2) y = 16'hFFFF - 16'($urandom_range(1));
      end else if (op == OP_ADD_DAYS) begin
        pick = $urandom_range(9);
        if (pick < 7) cnt = 10'($urandom_range(0, 40));
        else if (pick == 7) cnt = (($urandom_range(1) != 0) ? 10'h3FF : 10'd0);
      end
      send_date_op(op, m, d, y, cnt);
    end
  endtask

  // result check
  always @(posedge clk) begin
    date_t want;
    if (rst_n && out_valid) begin
      if (expected_dates.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("%0t: unexpected result %0d/%0d/%0d", $realtime, out_data.month_out,
                   out_data.day_out, out_data.year_out);
      end else begin
        want = expected_dates.pop_front();
        checked_count++;
        if (out_data.month_out !== want.month || out_data.day_out !== want.day ||
            out_data.year_out !== want.year) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("%0t: date mismatch exp m=%0d d=%0d y=%0d got m=%0d d=%0d y=%0d",
                     $realtime, want.month, want.day, want.year, out_data.month_out,
                     out_data.day_out, out_data.year_out);
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d idle cycles", quiet_cycles);
      $display("** calendar_date_counter_core: FAILED **");
      $finish;
    end
  end

  initial begin
    cal_date       = '{month: 4'd1, day: 5'd1, year: 16'(RESET_YEAR)};
    gap_pct        = 26;
    sent_count     = 0;
    checked_count  = 0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    foreach (op_count[i]) op_count[i] = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_value();
    test_set_clamping();
    test_month_end();
    test_year_wrap();
    test_add_days();
    test_random_traffic(320, 26);
    test_random_traffic(320, 48);
    test_random_traffic(310, 0);

    start <= 1'b0;
    while (expected_dates.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_dates.size() != 0) mismatch_count++;

    $display("%0d transactions sent, %0d results checked, %0d mismatches", sent_count,
             checked_count, mismatch_count);
    $display("set %0d, add day %0d, add month %0d, add year %0d, add days %0d, unused codes %0d",
             op_count[OP_SET], op_count[OP_ADD_DAY], op_count[OP_ADD_MONTH],
             op_count[OP_ADD_YEAR], op_count[OP_ADD_DAYS],
             op_count[OP_RSVD_5] + op_count[OP_RSVD_6] + op_count[OP_RSVD_7]);
    if (mismatch_count == 0) begin
      $display("** calendar_date_counter_core: PASSED **");
    end else begin
      $display("** calendar_date_counter_core: FAILED **");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/cal_pkg.sv
rtl/core/cal_step_unit.sv
rtl/core/calendar_date_counter_core.sv
verif/tb_calendar_date_counter_core.sv
